FILE: sv/quantum_round_robin_scheduler_defines.svh
// Assertion macros for the quantum round-robin scheduler.
`ifndef QUANTUM_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`define QUANTUM_ROUND_ROBIN_SCHEDULER_DEFINES_SVH
`ifndef SYNTH
`define QRRS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qrrs assertion failed");
`define QRRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qrrs assertion failed");
`else
`define QRRS_ASSERT_SAME(lbl, ante, cons)
`define QRRS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: sv/qrrs_pkg.sv
// Shared constants and types of the quantum round-robin scheduler.
package qrrs_pkg;
    localparam int DEPTH    = 64;
    localparam int ID_WIDTH = 32;
    localparam int AW       = $clog2(DEPTH);
    localparam int CW       = AW + 1;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_ERASE  = 3'd1;
    localparam logic [2:0] OP_GET    = 3'd2;
    localparam logic [2:0] OP_PEEK   = 3'd3;
    localparam logic [2:0] OP_CLEAR  = 3'd4;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_DUP       = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam logic [1:0] CFG_MODE    = 2'd0;
    localparam logic [1:0] CFG_QUANTUM = 2'd1;

    typedef struct packed {
        logic [AW-1:0] nxt;
        logic [AW-1:0] prv;
    } t_link;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN,
        S_INS_A, S_INS_B, S_INS_C, S_INS_D,
        S_ER_A, S_ER_B, S_ER_C, S_ER_D,
        S_GET_A, S_GET_B, S_RESP
    } t_state;
endpackage

FILE: sv/qrrs_ram.sv
// Simple dual-port synchronous RAM with registered read.
module qrrs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end
endmodule

FILE: sv/quantum_round_robin_scheduler.sv
// Quantum round-robin scheduler: ring of identifiers with a serving cursor.
// Usage: each request on the input channel (i_in_valid / o_in_stall) carries
// an opcode, an identifier and a byte count; it produces exactly one result
// on the output channel (o_out_valid / i_out_stall): served identifier,
// status and ring-empty flag. Requests are handled one at a time; o_in_stall
// is high while a request is in progress.
// Insert and erase sweep the identifier memory, one slot a cycle; a
// successful insert or erase then relinks the ring where needed. get_next
// reads the cursor's identifier and link, then updates the turn counter and
// the cursor; peek only reads. Clear, unused opcodes and requests refused on
// an empty ring go straight to the result stage.
// The next request is taken in the cycle after the result is loaded. The
// identifier and link memories each give one read per cycle; that port sets
// the search time.
// The result sits in an output register; a new request is accepted while it
// waits, and the next result holds inside until the receiver takes the
// current one. Configuration writes (i_cfg_valid / o_cfg_ready) are taken in
// every cycle and must come only while the block is idle.
// Synchronous reset empties the ring, clears the cursor and the turn counter,
// sets the mode to turn counting and the quantum to one.
`include "quantum_round_robin_scheduler_defines.svh"
module quantum_round_robin_scheduler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_ident,
    input  logic [15:0] i_byte_count,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_served_ident,
    output logic [2:0]  o_status,
    output logic        o_ring_empty,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import qrrs_pkg::*;

    t_state               r_state, n_state;
    logic [2:0]           r_op, n_op;
    logic [ID_WIDTH-1:0]  r_id, n_id;
    logic [15:0]          r_bytes, n_bytes;
    logic [CW-1:0]        r_count, n_count;
    logic [AW-1:0]        r_cursor, n_cursor;
    logic [31:0]          r_turn, n_turn;
    logic                 r_mode, n_mode;
    logic [31:0]          r_quantum, n_quantum;
    logic [DEPTH-1:0]     r_valid, n_valid;
    logic [CW-1:0]        r_scan, n_scan;
    logic                 r_cmp_v, n_cmp_v;
    logic [AW-1:0]        r_cmp_slot, n_cmp_slot;
    logic                 r_found_v, n_found_v;
    logic [AW-1:0]        r_found, n_found;
    logic                 r_free_v, n_free_v;
    logic [AW-1:0]        r_free, n_free;
    logic [AW-1:0]        r_slot, n_slot;
    logic [AW-1:0]        r_n, n_n;
    logic [AW-1:0]        r_p, n_p;
    logic [31:0]          r_res_ident, n_res_ident;
    logic [2:0]           r_res_status, n_res_status;
    logic                 r_ov, n_ov;
    logic [31:0]          r_o_ident, n_o_ident;
    logic [2:0]           r_o_status, n_o_status;
    logic                 r_o_empty, n_o_empty;

    logic                 id_we;
    logic [AW-1:0]        id_waddr, id_raddr;
    logic [ID_WIDTH-1:0]  id_wdata, id_rdata;
    logic                 lk_we;
    logic [AW-1:0]        lk_waddr, lk_raddr;
    t_link                lk_wdata, lk_rdata;

    logic                 in_acc, hit, fre, last, f_v, fr_v, load;
    logic [AW-1:0]        f_slot, fr_slot;
    logic [32:0]          sum;
    logic [31:0]          add;

    qrrs_ram #(.DEPTH(DEPTH), .WIDTH(ID_WIDTH)) u_id_ram (
        .i_clk  (i_clk),
        .i_we   (id_we),
        .i_waddr(id_waddr),
        .i_wdata(id_wdata),
        .i_raddr(id_raddr),
        .o_rdata(id_rdata)
    );

    qrrs_ram #(.DEPTH(DEPTH), .WIDTH(2 * AW)) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (lk_we),
        .i_waddr(lk_waddr),
        .i_wdata(lk_wdata),
        .i_raddr(lk_raddr),
        .o_rdata(lk_rdata)
    );

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_out_valid    = r_ov;
    assign o_served_ident = r_o_ident;
    assign o_status       = r_o_status;
    assign o_ring_empty   = r_o_empty;
    assign in_acc         = i_in_valid && !o_in_stall;

    // search bookkeeping for the slot returning from memory this cycle
    assign hit     = r_cmp_v && r_valid[r_cmp_slot] && (id_rdata == r_id);
    assign fre     = r_cmp_v && !r_valid[r_cmp_slot];
    assign last    = r_cmp_v && (r_cmp_slot == AW'(DEPTH - 1));
    assign f_v     = r_found_v || hit;
    assign f_slot  = r_found_v ? r_found : r_cmp_slot;
    assign fr_v    = r_free_v || fre;
    assign fr_slot = r_free_v ? r_free : r_cmp_slot;

    assign add  = r_mode ? {16'd0, r_bytes} : 32'd1;
    assign sum  = {1'b0, r_turn} + {1'b0, add};
    assign load = (r_state == S_RESP) && !(r_ov && i_out_stall);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_id         = r_id;
        n_bytes      = r_bytes;
        n_count      = r_count;
        n_cursor     = r_cursor;
        n_turn       = r_turn;
        n_mode       = r_mode;
        n_quantum    = r_quantum;
        n_valid      = r_valid;
        n_scan       = r_scan;
        n_cmp_v      = r_cmp_v;
        n_cmp_slot   = r_cmp_slot;
        n_found_v    = r_found_v;
        n_found      = r_found;
        n_free_v     = r_free_v;
        n_free       = r_free;
        n_slot       = r_slot;
        n_n          = r_n;
        n_p          = r_p;
        n_res_ident  = r_res_ident;
        n_res_status = r_res_status;
        n_ov         = r_ov && i_out_stall;
        n_o_ident    = r_o_ident;
        n_o_status   = r_o_status;
        n_o_empty    = r_o_empty;
        id_we        = 1'b0;
        id_waddr     = r_slot;
        id_wdata     = r_id;
        id_raddr     = r_cursor;
        lk_we        = 1'b0;
        lk_waddr     = r_slot;
        lk_wdata     = '{nxt: r_cursor, prv: r_p};
        lk_raddr     = r_cursor;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_op         = i_opcode;
                    n_id         = i_ident[ID_WIDTH-1:0];
                    n_bytes      = i_byte_count;
                    n_res_ident  = '0;
                    n_res_status = ST_OK;
                    n_scan       = '0;
                    n_cmp_v      = 1'b0;
                    n_found_v    = 1'b0;
                    n_free_v     = 1'b0;
                    n_state      = S_RESP;
                    case (i_opcode)
                        OP_INSERT: n_state = S_SCAN;
                        OP_ERASE: begin
                            if (r_count == '0) begin
                                n_res_status = ST_NOT_FOUND;
                            end else begin
                                n_state = S_SCAN;
                            end
                        end
                        OP_GET, OP_PEEK: begin
                            if (r_count == '0) begin
                                n_res_status = ST_EMPTY;
                            end else begin
                                n_state = S_GET_A;
                            end
                        end
                        OP_CLEAR: begin
                            n_valid  = '0;
                            n_count  = '0;
                            n_cursor = '0;
                            n_turn   = '0;
                        end
                        default: n_state = S_RESP;
                    endcase
                end
            end
            S_SCAN: begin
                id_raddr   = r_scan[AW-1:0];
                n_cmp_v    = !r_scan[AW];
                n_cmp_slot = r_scan[AW-1:0];
                if (!r_scan[AW]) begin
                    n_scan = r_scan + CW'(1);
                end
                n_found_v = f_v;
                n_found   = f_slot;
                n_free_v  = fr_v;
                n_free    = fr_slot;
                if (last) begin
                    n_state = S_RESP;
                    if (r_op == OP_INSERT) begin
                        if (f_v) begin
                            n_res_status = ST_DUP;
                        end else if (!fr_v || r_count >= CW'(DEPTH)) begin
                            n_res_status = ST_FULL;
                        end else begin
                            n_slot           = fr_slot;
                            id_we            = 1'b1;
                            id_waddr         = fr_slot;
                            n_valid[fr_slot] = 1'b1;
                            n_count          = r_count + CW'(1);
                            if (r_count == '0) begin
                                lk_we    = 1'b1;
                                lk_waddr = fr_slot;
                                lk_wdata = '{nxt: fr_slot, prv: fr_slot};
                                n_cursor = fr_slot;
                            end else begin
                                lk_raddr = r_cursor;
                                n_state  = S_INS_A;
                            end
                        end
                    end else begin
                        if (!f_v) begin
                            n_res_status = ST_NOT_FOUND;
                        end else begin
                            n_slot   = f_slot;
                            lk_raddr = f_slot;
                            n_state  = S_ER_A;
                        end
                    end
                end
            end
            S_INS_A: begin
                // link new slot between predecessor and cursor
                n_p      = lk_rdata.prv;
                lk_we    = 1'b1;
                lk_waddr = r_slot;
                lk_wdata = '{nxt: r_cursor, prv: lk_rdata.prv};
                lk_raddr = lk_rdata.prv;
                n_state  = S_INS_B;
            end
            S_INS_B: begin
                lk_we    = 1'b1;
                lk_waddr = r_p;
                lk_wdata = '{nxt: r_slot, prv: lk_rdata.prv};
                n_state  = S_INS_C;
            end
            S_INS_C: begin
                lk_raddr = r_cursor;
                n_state  = S_INS_D;
            end
            S_INS_D: begin
                lk_we    = 1'b1;
                lk_waddr = r_cursor;
                lk_wdata = '{nxt: lk_rdata.nxt, prv: r_slot};
                n_state  = S_RESP;
            end
            S_ER_A: begin
                n_n             = lk_rdata.nxt;
                n_p             = lk_rdata.prv;
                n_valid[r_slot] = 1'b0;
                n_count         = r_count - CW'(1);
                if (r_slot == r_cursor) begin
                    n_cursor = (r_count == CW'(1)) ? '0 : lk_rdata.nxt;
                    n_turn   = '0;
                end
                if (r_count > CW'(1)) begin
                    lk_raddr = lk_rdata.prv;
                    n_state  = S_ER_B;
                end else begin
                    n_state = S_RESP;
                end
            end
            S_ER_B: begin
                lk_we    = 1'b1;
                lk_waddr = r_p;
                lk_wdata = '{nxt: r_n, prv: lk_rdata.prv};
                n_state  = S_ER_C;
            end
            S_ER_C: begin
                lk_raddr = r_n;
                n_state  = S_ER_D;
            end
            S_ER_D: begin
                lk_we    = 1'b1;
                lk_waddr = r_n;
                lk_wdata = '{nxt: lk_rdata.nxt, prv: r_p};
                n_state  = S_RESP;
            end
            S_GET_A: begin
                n_res_ident = 32'(id_rdata);
                n_n         = lk_rdata.nxt;
                if (r_op == OP_PEEK) begin
                    n_state = S_RESP;
                end else begin
                    // saturate the turn counter
                    n_turn  = sum[32] ? '1 : sum[31:0];
                    n_state = S_GET_B;
                end
            end
            S_GET_B: begin
                if (r_turn >= r_quantum) begin
                    n_cursor = r_n;
                    n_turn   = '0;
                end
                n_state = S_RESP;
            end
            S_RESP: begin
                if (load) begin
                    n_ov       = 1'b1;
                    n_o_ident  = r_res_ident;
                    n_o_status = r_res_status;
                    n_o_empty  = (r_count == '0);
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MODE: begin
                    if (i_cfg_data[0] != r_mode) begin
                        n_turn = '0;
                    end
                    n_mode = i_cfg_data[0];
                end
                CFG_QUANTUM: n_quantum = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cursor  <= '0;
            r_turn    <= '0;
            r_mode    <= 1'b0;
            r_quantum <= 32'd1;
            r_valid   <= '0;
            r_ov      <= 1'b0;
            r_scan    <= '0;
            r_cmp_v   <= 1'b0;
            r_found_v <= 1'b0;
            r_free_v  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_cursor  <= n_cursor;
            r_turn    <= n_turn;
            r_mode    <= n_mode;
            r_quantum <= n_quantum;
            r_valid   <= n_valid;
            r_ov      <= n_ov;
            r_scan    <= n_scan;
            r_cmp_v   <= n_cmp_v;
            r_found_v <= n_found_v;
            r_free_v  <= n_free_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_id         <= n_id;
        r_bytes      <= n_bytes;
        r_cmp_slot   <= n_cmp_slot;
        r_found      <= n_found;
        r_free       <= n_free;
        r_slot       <= n_slot;
        r_n          <= n_n;
        r_p          <= n_p;
        r_res_ident  <= n_res_ident;
        r_res_status <= n_res_status;
        r_o_ident    <= n_o_ident;
        r_o_status   <= n_o_status;
        r_o_empty    <= n_o_empty;
    end

    `QRRS_ASSERT_SAME(a_count_matches_valid, 1'b1, $countones(r_valid) == int'(r_count))
    `QRRS_ASSERT_SAME(a_count_bound, 1'b1, r_count <= CW'(DEPTH))
    `QRRS_ASSERT_SAME(a_cursor_live, (r_state == S_IDLE) && (r_count != '0), r_valid[r_cursor])
    `QRRS_ASSERT_NEXT(a_accept_busy, in_acc, r_state != S_IDLE)
endmodule

FILE: tb/qrrs_checker.sv
// Checker for the quantum round-robin scheduler: predicts each result and compares.
module qrrs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_ident,
    input  logic [15:0] i_byte_count,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_served_ident,
    input  logic [2:0]  i_status,
    input  logic        i_ring_empty,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending,
    output logic        o_accept_seen
);
    import qrrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] served;
        logic [2:0]  status;
        logic        empty;
    } t_sched_result;

    t_sched_result result_queue[$];

    logic [31:0]   ids[DEPTH];
    logic [AW-1:0] nxt[DEPTH];
    logic [AW-1:0] prv[DEPTH];
    logic          used[DEPTH];
    logic [AW-1:0] cur;
    int            count;
    logic [31:0]   turns;
    logic          by_bytes;
    logic [31:0]   quantum;

    function automatic int find_id(logic [31:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (used[i] && ids[i] == id) return i;
        return -1;
    endfunction

    function automatic t_sched_result schedule(logic [2:0] op, logic [31:0] id,
                                               logic [15:0] nbytes);
        t_sched_result r;
        int s;
        logic [AW-1:0] p, n;
        logic [32:0] sum;
        r = '0;
        r.status = ST_OK;
        case (op)
            OP_INSERT: begin
                if (find_id(id) >= 0) begin
                    r.status = ST_DUP;
                end else if (count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    s = -1;
                    for (int i = DEPTH - 1; i >= 0; i--) if (!used[i]) s = i;
                    ids[s] = id;
                    used[s] = 1'b1;
                    if (count == 0) begin
                        nxt[s] = AW'(s); prv[s] = AW'(s); cur = AW'(s);
                    end else begin
                        p = prv[cur];
                        nxt[s] = cur; prv[s] = p;
                        nxt[p] = AW'(s); prv[cur] = AW'(s);
                    end
                    count++;
                end
            end
            OP_ERASE: begin
                s = find_id(id);
                if (count == 0 || s < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    n = nxt[s]; p = prv[s];
                    if (s == cur) begin
                        cur = (count == 1) ? '0 : n;
                        turns = '0;
                    end
                    if (count > 1) begin
                        nxt[p] = n; prv[n] = p;
                    end
                    used[s] = 1'b0;
                    count--;
                end
            end
            OP_GET: begin
                if (count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.served = ids[cur];
                    sum = turns + (by_bytes ? 32'(nbytes) : 32'd1);
                    turns = sum[32] ? '1 : sum[31:0];
                    if (turns >= quantum) begin
                        cur = nxt[cur];
                        turns = '0;
                    end
                end
            end
            OP_PEEK: begin
                if (count == 0) r.status = ST_EMPTY;
                else r.served = ids[cur];
            end
            OP_CLEAR: begin
                for (int i = 0; i < DEPTH; i++) used[i] = 1'b0;
                count = 0; cur = '0; turns = '0;
            end
            default: ;
        endcase
        r.empty = (count == 0);
        return r;
    endfunction

    assign o_pending = result_queue.size();

    always @(posedge i_clk) begin
        t_sched_result got, want;
        logic seen;
        seen = 1'b0;
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) used[i] = 1'b0;
            count = 0; cur = '0; turns = '0; by_bytes = 1'b0; quantum = 32'd1;
            o_fail_count <= 0;
            result_queue.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_MODE) begin
                    if (i_cfg_data[0] != by_bytes) turns = '0;
                    by_bytes = i_cfg_data[0];
                end else if (i_cfg_index == CFG_QUANTUM) begin
                    quantum = i_cfg_data;
                end
            end
            if (i_in_valid && !i_in_stall) begin
                result_queue.push_back(schedule(i_opcode, i_ident, i_byte_count));
                seen = 1'b1;
            end
            if (i_out_valid && !i_out_stall) begin
                seen = 1'b1;
                got = '{i_served_ident, i_status, i_ring_empty};
                if (result_queue.size() == 0) begin
                    $error("result with no request waiting");
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = result_queue.pop_front();
                    if (got != want) begin
                        if (got.served != want.served)
                            $error("served_ident: expected %h, got %h", want.served, got.served);
                        if (got.status != want.status)
                            $error("status: expected %0d, got %0d", want.status, got.status);
                        if (got.empty != want.empty)
                            $error("ring_empty: expected %0d, got %0d", want.empty, got.empty);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_accept_seen <= seen;
    end
endmodule

FILE: tb/tb_quantum_round_robin_scheduler.sv
// Testbench top for the quantum round-robin scheduler: stimulus and verdict.
module tb_quantum_round_robin_scheduler;
    import qrrs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [2:0]  i_opcode = '0;
    logic [31:0] i_ident = '0;
    logic [15:0] i_byte_count = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [31:0] o_served_ident;
    logic [2:0]  o_status;
    logic        o_ring_empty;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [31:0] i_cfg_data = '0;

    int   fail_count;
    int   pending;
    logic accept_seen;
    int   idle_cycles = 0;
    logic long_hold = 1'b0;
    logic [31:0] id_pool[16];

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    quantum_round_robin_scheduler uut (.*);

    qrrs_checker checker_i (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_opcode, .i_ident,
        .i_byte_count, .i_out_valid(o_out_valid), .i_out_stall, .i_served_ident(o_served_ident),
        .i_status(o_status), .i_ring_empty(o_ring_empty), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_index, .i_cfg_data, .o_fail_count(fail_count), .o_pending(pending),
        .o_accept_seen(accept_seen)
    );

    always @(posedge i_clk) begin
        if (accept_seen || !i_rst_n) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Receiver: random stall per result, or a long hold-off when requested.
    initial begin
        int gap;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                long_hold = 1'b0;
                i_out_stall <= 1'b0;
            end else if (o_out_valid && !i_out_stall) begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
                if (gap > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (gap) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Valid stays high after an accept so a request with no gap follows at once.
    task automatic send_request(logic [2:0] op, logic [31:0] id, logic [15:0] nbytes,
                                int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode <= op;
        i_ident <= id;
        i_byte_count <= nbytes;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic write_register(logic [1:0] index, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_id();
        return ($urandom_range(0, 9) == 0) ? $urandom() : id_pool[$urandom_range(0, 15)];
    endfunction

    task automatic random_phase(int n, int fill);
        int r, gap;
        logic [2:0] op;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < fill) op = OP_INSERT;
            else if (r < fill + 15) op = OP_ERASE;
            else if (r < 88) op = OP_GET;
            else if (r < 95) op = OP_PEEK;
            else if (r < 97) op = OP_CLEAR;
            else op = 3'($urandom_range(5, 7));
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            send_request(op, pick_id(), 16'($urandom_range(0, 3) == 0 ? $urandom()
                         : $urandom_range(0, 8)), gap);
        end
    endtask

    initial begin
        for (int i = 0; i < 16; i++) id_pool[i] = $urandom();
        id_pool[0] = '0;
        id_pool[1] = '1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty ring cases, extremes, duplicate.
        send_request(OP_GET, '0, '0, 0);
        send_request(OP_PEEK, '0, '0, 0);
        send_request(OP_ERASE, 32'h5, '0, 0);
        send_request(OP_INSERT, '0, '0, 0);
        send_request(OP_INSERT, '1, '1, 0);
        send_request(OP_INSERT, '1, '0, 0);
        send_request(OP_INSERT, 32'hA5A5_5A5A, '0, 0);
        send_request(OP_PEEK, '0, '0, 0);
        send_request(OP_GET, '0, '0, 0);
        send_request(OP_GET, '0, '0, 0);
        send_request(OP_ERASE, 32'h1234, '0, 0);
        send_request(OP_ERASE, '1, '0, 0);
        send_request(3'd5, '1, '1, 0);
        send_request(3'd7, '0, '0, 0);
        drain();
        write_register(CFG_MODE, 32'd1);
        write_register(CFG_QUANTUM, '1);
        for (int i = 0; i < 4; i++) send_request(OP_GET, '0, '1, 0);
        send_request(OP_ERASE, '0, '0, 0);
        send_request(OP_GET, '0, 16'd7, 0);
        send_request(OP_CLEAR, '0, '0, 0);
        send_request(OP_PEEK, '0, '0, 0);
        drain();
        write_register(CFG_MODE, 32'd1);
        write_register(CFG_QUANTUM, 32'd0);
        write_register(2'd3, 32'd9);

        // Fill to capacity, then two inserts into the full ring.
        for (int i = 0; i < DEPTH + 2; i++) send_request(OP_INSERT, 32'h1000 + i, '0, 0);
        send_request(OP_GET, '0, '0, 0);
        drain();

        // Long receiver hold-off while requests keep coming.
        long_hold = 1'b1;
        for (int i = 0; i < 6; i++) send_request(OP_ERASE, 32'h1000 + 2 * i, '0, 0);
        send_request(OP_CLEAR, '0, '0, 0);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: begin write_register(CFG_MODE, 32'd0); write_register(CFG_QUANTUM, 32'd1); end
                1: begin write_register(CFG_MODE, 32'd0); write_register(CFG_QUANTUM, 32'd3); end
                2: begin write_register(CFG_MODE, 32'd1); write_register(CFG_QUANTUM, 32'd10); end
                3: begin write_register(CFG_MODE, 32'd1); write_register(CFG_QUANTUM, '1); end
                4: begin write_register(CFG_MODE, 32'd0); write_register(CFG_QUANTUM, 32'd0); end
                default: begin
                    write_register(CFG_MODE, 32'd1);
                    write_register(CFG_QUANTUM, 32'd40000);
                end
            endcase
            random_phase(300, (ph % 2 == 0) ? 30 : 20);
            drain();
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
